// ----- sv/cafb_pkg.sv -----
// shared constants and types for the congestion aware flowlet balancer
// no dependencies

package cafb_pkg;

  localparam int unsigned Leaves = 4;
  localparam int unsigned Spines = 2;
  localparam int unsigned FlowletEntries = 1024;
  localparam int unsigned LinkCount = Leaves * Spines;
  localparam int unsigned LinkW = $clog2(LinkCount);
  localparam int unsigned SpineW = $clog2(Spines);
  localparam int unsigned FlIdxW = $clog2(FlowletEntries);

  localparam logic [31:0] HashMulA = 32'd2654435761;
  localparam logic [31:0] HashMulB = 32'd2246822519;
  localparam logic [31:0] MinFlowBytes = 32'd1000;
  localparam logic [16:0] CeOne = 17'd65536;

  typedef enum logic [1:0] {
    CfgGap   = 2'd0,
    CfgDelay = 2'd1,
    CfgIntv  = 2'd2,
    CfgQmax  = 2'd3
  } cfg_idx_e;

  // flowlet entry: valid, tag, last seen time, spine
  typedef struct packed {
    logic              valid;
    logic [31:0]       tag;
    logic [47:0]       seen;
    logic [SpineW-1:0] spine;
  } fl_entry_t;

  // divider request from the top level
  typedef struct packed {
    logic        start;
    logic [50:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

// ----- sv/congestion_aware_flowlet_balancer_core.sv -----
// top level of the congestion aware flowlet balancer
// uses cafb_pkg, cafb_ram and cafb_div

// Usage
// One input channel (in_valid_i / in_ready_o) carries a word that is either an
// uplink measurement (op 0) or a flow event (op 1). Every accepted word gives
// exactly one result word on the output channel (out_valid_o / out_ready_i).
// A flow event has these steps: hash multiply, hash, the flowlet memory is
// read, the entry is compared and the least congested spine picked while the
// entry is written back, then the result is loaded. A flow under 1000 bytes
// or from a leaf out of range skips to the result. In a measurement,
// utilization and queue fill each go through the shared bit-serial divider
// (17 steps each) unless zero or saturated, then per-link state is written.
// The block works on one word at a time; the next word is taken the cycle
// after a result is loaded into the output register.
// When the receiver stalls, the finished result waits in the output register
// and the next word finishes its work but holds its result until then; the
// input stalls after that.
// Reset clears the per-link state (congestion, update time and byte count are
// flops with reset), loads the default register values and starts a clearing
// pass over all 1024 flowlet memory entries, with in_ready_o low meanwhile.
// Configuration writes are taken at any time.

module congestion_aware_flowlet_balancer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [47:0] time_ns_i,
  input  logic [1:0]  leaf_index_i,
  input  logic        spine_index_i,
  input  logic [47:0] byte_counter_i,
  input  logic [15:0] queue_packets_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [31:0] flow_tx_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [31:0] flow_hash_o,
  output logic        chosen_spine_o,
  output logic        new_flow_o,
  output logic        flowlet_boundary_o,
  output logic        ce_updated_o,
  output logic [16:0] ce_value_o
);

  localparam int unsigned SpineW = cafb_pkg::SpineW;
  localparam int unsigned LinkW = cafb_pkg::LinkW;
  localparam int unsigned FlIdxW = cafb_pkg::FlIdxW;
  localparam int unsigned EntW = $bits(cafb_pkg::fl_entry_t);

  typedef enum logic [3:0] {
    StClear, StIdle, StHashMul, StHash, StFlRead, StFlDecide, StMeasRd, StUtil,
    StUtilWait, StQfill, StQWait, StMeasWr, StEmit
  } state_e;

  // configuration registers
  logic [29:0] gap_q, delay_q;
  logic [31:0] intv_q;
  logic [15:0] qmax_q;

  // per-link state in flops (eight entries, reset to zero)
  logic [16:0] ce_q [cafb_pkg::LinkCount];
  logic [47:0] ce_time_q [cafb_pkg::LinkCount];
  logic [47:0] prev_bytes_q [cafb_pkg::LinkCount];

  state_e      state_q;
  logic [FlIdxW-1:0] clr_cnt_q;
  logic [47:0] time_q, bytes_q;
  logic [LinkW-1:0] link_q;
  logic [15:0] qpk_q;
  logic [31:0] sa_q, da_q;
  logic [7:0]  pr_q;
  logic [15:0] sp_q, dp_q;
  logic [31:0] prod_a_q, prod_b_q;
  logic [31:0] hash_q;
  logic [16:0] util_q, ce_calc;
  logic        skip;

  // working result
  logic        res_acc_q, res_new_q, res_bnd_q, res_upd_q;
  logic [31:0] res_hash_q;
  logic [SpineW-1:0] res_spine_q;
  logic [16:0] res_ce_q;

  // output register
  logic        out_acc_q, out_new_q, out_bnd_q, out_upd_q;
  logic [31:0] out_hash_q;
  logic [SpineW-1:0] out_spine_q;
  logic [16:0] out_ce_q;

  cafb_pkg::div_req_t div_req;
  logic        div_done;
  logic [16:0] div_quot;

  cafb_pkg::fl_entry_t fl_rd, fl_wr, fl_wdata;
  logic        fl_we;
  logic [FlIdxW-1:0] fl_waddr;

  assign in_ready_o = (state_q == StIdle);

  // flowlet memory, cleared by a pass after reset
  cafb_ram #(.Width(EntW), .Depth(cafb_pkg::FlowletEntries)) u_fl_ram (
    .clk_i  (clk_i),
    .we_i   (fl_we),
    .waddr_i(fl_waddr),
    .wdata_i(fl_wdata),
    .raddr_i(hash_q[FlIdxW-1:0]),
    .rdata_o(fl_rd)
  );

  cafb_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

  // measurement numerator: byte delta times eight, or queue depth
  logic [47:0] delta;
  logic [50:0] util_num;
  logic [50:0] q_num;
  logic        util_sat, q_sat;
  assign delta    = bytes_q - prev_bytes_q[link_q];
  assign util_num = {delta, 3'b000};
  assign q_num    = {35'd0, qpk_q};
  assign util_sat = (util_num >= {19'd0, intv_q});
  assign q_sat    = ({35'd0, qpk_q} >= {35'd0, qmax_q});

  // least congested spine of the leaf held in sa_q
  logic [SpineW-1:0] best;
  logic [16:0] best_ce;
  logic [LinkW-1:0] lbase;
  always_comb begin
    lbase   = LinkW'(sa_q[17:16]) * LinkW'(cafb_pkg::Spines);
    best    = '0;
    best_ce = ce_q[lbase];
    for (int s = 1; s < cafb_pkg::Spines; s++) begin
      if (ce_q[lbase + LinkW'(s)] < best_ce) begin
        best_ce = ce_q[lbase + LinkW'(s)];
        best    = SpineW'(s);
      end
    end
  end

  // flow decision on the read entry
  logic hit, gap_over;
  logic [47:0] gap;
  assign hit      = fl_rd.valid && (fl_rd.tag == hash_q);
  assign gap      = time_q - fl_rd.seen;
  assign gap_over = (time_q >= fl_rd.seen) && (gap > {18'd0, gap_q});

  // feedback delay check
  logic [47:0] since;
  logic        ce_due;
  assign since  = time_q - ce_time_q[link_q];
  assign ce_due = (time_q >= ce_time_q[link_q]) && (since >= {18'd0, delay_q});
  assign ce_calc = (util_q > div_quot) ? util_q : div_quot;

  assign skip = (flow_tx_bytes_i < cafb_pkg::MinFlowBytes) || (src_addr_i[23:16] >=
                8'(cafb_pkg::Leaves));

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = util_num;
    div_req.den   = intv_q;
    if (state_q == StUtil) begin
      div_req.start = !(util_num == '0 || util_sat);
    end else if (state_q == StQfill) begin
      div_req.num   = q_num;
      div_req.den   = {16'd0, qmax_q};
      div_req.start = !(qpk_q == '0 || q_sat);
    end
  end

  always_comb begin
    fl_wr.valid = 1'b1;
    fl_wr.tag   = hash_q;
    fl_wr.seen  = time_q;
    fl_wr.spine = (!hit || gap_over) ? best : fl_rd.spine;
    fl_we       = (state_q == StFlDecide) || (state_q == StClear);
    fl_waddr    = (state_q == StClear) ? clr_cnt_q : hash_q[FlIdxW-1:0];
    fl_wdata    = (state_q == StClear) ? '0 : fl_wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q   <= 30'd300000;
      delay_q <= 30'd100000;
      intv_q  <= 32'd100000;
      qmax_q  <= 16'd100;
    end else if (cfg_we_i) begin
      case (cafb_pkg::cfg_idx_e'(cfg_index_i))
        cafb_pkg::CfgGap:   gap_q   <= cfg_data_i[29:0];
        cafb_pkg::CfgDelay: delay_q <= cfg_data_i[29:0];
        cafb_pkg::CfgIntv:  intv_q  <= cfg_data_i;
        cafb_pkg::CfgQmax:  qmax_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      out_valid_o <= 1'b0;
      out_acc_q   <= 1'b0;
      out_hash_q  <= '0;
      out_spine_q <= '0;
      out_new_q   <= 1'b0;
      out_bnd_q   <= 1'b0;
      out_upd_q   <= 1'b0;
      out_ce_q    <= '0;
      for (int i = 0; i < cafb_pkg::LinkCount; i++) begin
        ce_q[i]         <= '0;
        ce_time_q[i]    <= '0;
        prev_bytes_q[i] <= '0;
      end
    end else begin
      if (state_q == StEmit && (!out_valid_o || out_ready_i)) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StClear: begin
          clr_cnt_q <= clr_cnt_q + FlIdxW'(1);
          if (clr_cnt_q == '1) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) begin
            res_acc_q   <= 1'b0;
            res_hash_q  <= '0;
            res_spine_q <= '0;
            res_new_q   <= 1'b0;
            res_bnd_q   <= 1'b0;
            res_upd_q   <= 1'b0;
            res_ce_q    <= '0;
            time_q <= time_ns_i;
            bytes_q <= byte_counter_i;
            qpk_q  <= queue_packets_i;
            link_q <= LinkW'({leaf_index_i, spine_index_i});
            sa_q <= src_addr_i; da_q <= dst_addr_i; pr_q <= protocol_i;
            sp_q <= src_port_i; dp_q <= dst_port_i;
            if (op_i) state_q <= skip ? StEmit : StHashMul;
            else state_q <= StUtil;
          end
        end
        StHashMul: begin
          prod_a_q <= 32'(sa_q * cafb_pkg::HashMulA);
          prod_b_q <= 32'(da_q * cafb_pkg::HashMulB);
          state_q  <= StHash;
        end
        StHash: begin
          hash_q <= prod_a_q ^ prod_b_q ^ {8'd0, pr_q, 16'd0} ^ {8'd0, sp_q, 8'd0}
                    ^ {16'd0, dp_q};
          state_q <= StFlRead;
        end
        StFlRead: state_q <= StFlDecide;
        StFlDecide: begin
          res_acc_q   <= 1'b1;
          res_hash_q  <= hash_q;
          res_spine_q <= fl_wr.spine;
          res_new_q   <= !hit;
          res_bnd_q   <= hit && gap_over;
          state_q     <= StEmit;
        end
        StUtil: begin
          util_q  <= (util_num == '0) ? 17'd0 : cafb_pkg::CeOne;
          state_q <= div_req.start ? StUtilWait : StQfill;
        end
        StUtilWait: begin
          if (div_done) begin
            util_q  <= div_quot;
            state_q <= StQfill;
          end
        end
        StQfill: begin
          if (!div_req.start) begin
            // queue fill is zero or saturated, no division
            res_ce_q <= (qpk_q == '0) ? util_q : cafb_pkg::CeOne;
            state_q <= StMeasWr;
          end else begin
            state_q <= StQWait;
          end
        end
        StQWait: begin
          if (div_done) begin
            res_ce_q <= ce_calc;
            state_q  <= StMeasWr;
          end
        end
        StMeasWr: begin
          if (ce_due) begin
            ce_q[link_q]      <= res_ce_q;
            ce_time_q[link_q] <= time_q;
            res_upd_q         <= 1'b1;
          end
          prev_bytes_q[link_q] <= bytes_q;
          state_q <= StEmit;
        end
        StEmit: begin
          if (!out_valid_o || out_ready_i) begin
            out_acc_q   <= res_acc_q;
            out_hash_q  <= res_hash_q;
            out_spine_q <= res_spine_q;
            out_new_q   <= res_new_q;
            out_bnd_q   <= res_bnd_q;
            out_upd_q   <= res_upd_q;
            out_ce_q    <= res_ce_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign accepted_o         = out_acc_q;
  assign flow_hash_o        = out_hash_q;
  assign chosen_spine_o     = out_spine_q;
  assign new_flow_o         = out_new_q;
  assign flowlet_boundary_o = out_bnd_q;
  assign ce_updated_o       = out_upd_q;
  assign ce_value_o         = out_ce_q;

  // a word is only taken when the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != StIdle)
    else $error("word taken without leaving idle");
  // congestion values never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_ce_q <= cafb_pkg::CeOne)
    else $error("congestion value above one");
  // flow results never report a congestion update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_acc_q |-> !out_upd_q && out_ce_q == '0)
    else $error("flow result carries measurement fields");
  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_hash_q) && $stable(out_ce_q))
    else $error("stalled result changed");

endmodule

// ----- sv/cafb_ram.sv -----
// generic single port write, single port read ram with registered read
// no dependencies

module cafb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/cafb_div.sv -----
// restoring divider, one quotient bit per cycle, 17 bit quotient
// uses cafb_pkg

module cafb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cafb_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [16:0]       quot_o
);

  // num < den holds at start, so num fits 32 bits and num*2^16/den fits 16 bits
  logic [32:0] rem_q, rem_d;
  logic [50:0] num_q;
  logic [31:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [16:0] quot_q;
  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    shifted = {rem_q, num_q[50]};
    trial   = shifted - {2'b0, den_q};
    rem_d   = trial[33] ? shifted[32:0] : trial[32:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        if (cnt_q == 5'd16) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  // datapath: remainder starts at num/2, then num bit 0 and 16 zeros are fed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {2'b0, req_i.num[31:1]};
      num_q  <= {req_i.num[0], 50'd0};
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[49:0], 1'b0};
      quot_q <= {quot_q[15:0], ~trial[33]};
    end
  end

  assign quot_o = quot_q;

endmodule
